@@ rtl/gsa_pkg.sv @@
// Shared types and constants for the generational slot allocator.
package gsa_pkg;

  localparam int SlotsDefault       = 64;
  localparam int GenBitsDefault     = 16;
  localparam int PayloadBitsDefault = 32;
  localparam int OwnerBits          = 32;

  typedef enum logic [1:0] {
    ACT_ALLOC   = 2'd0,
    ACT_RELEASE = 2'd1,
    ACT_LOOKUP  = 2'd2,
    ACT_CLEAR   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_INVALID = 2'd1,
    STAT_FULL    = 2'd2
  } status_t;

  typedef struct packed {
    logic    capture;
    logic    fetch;
    logic    exec;
    logic    alloc_reuse;
    logic    alloc_new;
    logic    release_slot;
    logic    clear;
    logic    read_entry;
    status_t report;
    logic    fix;
    logic    load_out;
  } gsa_cmd_t;

  typedef struct packed {
    action_t act;
    logic    can_reuse;
    logic    can_new;
    logic    handle_ok;
    logic    pos_differs;
  } gsa_stat_t;

endpackage

@@ rtl/gsa_ctrl.sv @@
// Controller state machine that sequences one request through fetch, execute and finish.
module gsa_ctrl
  import gsa_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  input  gsa_stat_t stat,
  output gsa_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_FETCH  = 4'b0010,
    S_EXEC   = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;
  logic   need_fix;
  logic   need_fix_next;
  logic   out_valid_next;
  logic   out_free;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    cmd            = '0;
    cmd.report     = STAT_OK;
    state_next     = state;
    need_fix_next  = need_fix;
    out_valid_next = out_valid && out_stall;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_FETCH;
        end
      end
      S_FETCH: begin
        cmd.fetch  = 1'b1;
        state_next = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec      = 1'b1;
        need_fix_next = 1'b0;
        case (stat.act)
          ACT_ALLOC: begin
            if (stat.can_reuse) begin
              cmd.alloc_reuse = 1'b1;
            end else if (stat.can_new) begin
              cmd.alloc_new = 1'b1;
            end else begin
              cmd.report = STAT_FULL;
            end
          end
          ACT_CLEAR: begin
            cmd.clear = 1'b1;
          end
          ACT_RELEASE, ACT_LOOKUP: begin
            if (stat.handle_ok) begin
              cmd.read_entry = 1'b1;
              if (stat.act == ACT_RELEASE) begin
                cmd.release_slot = 1'b1;
                need_fix_next    = stat.pos_differs;
              end
            end else begin
              cmd.report = STAT_INVALID;
            end
          end
          default: begin
            cmd.report = STAT_INVALID;
          end
        endcase
        state_next = S_FINISH;
      end
      S_FINISH: begin
        cmd.fix = need_fix;
        if (out_free) begin
          cmd.load_out   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      need_fix  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      need_fix  <= need_fix_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

@@ rtl/gsa_datapath.sv @@
// Datapath with the slot and dense memories, table registers, handle check and result register.
module gsa_datapath
  import gsa_pkg::*;
#(
  parameter int SLOTS        = SlotsDefault,
  parameter int GEN_BITS     = GenBitsDefault,
  parameter int PAYLOAD_BITS = PayloadBitsDefault,
  localparam int IdxW        = $clog2(SLOTS),
  localparam int CntW        = $clog2(SLOTS + 1)
) (
  input  logic                    clk,
  input  logic                    rst,
  input  gsa_cmd_t                cmd,
  output gsa_stat_t               stat,
  input  logic                    cfg_write,
  input  logic [GEN_BITS-1:0]     cfg_data,
  input  logic [1:0]              action,
  input  logic [OwnerBits-1:0]    handle_owner,
  input  logic [IdxW-1:0]         handle_index,
  input  logic [GEN_BITS-1:0]     handle_generation,
  input  logic [PAYLOAD_BITS-1:0] payload_in,
  output logic [1:0]              status,
  output logic [OwnerBits-1:0]    out_owner,
  output logic [IdxW-1:0]         out_index,
  output logic [GEN_BITS-1:0]     out_generation,
  output logic [IdxW-1:0]         dense_position,
  output logic [PAYLOAD_BITS-1:0] payload_out
);

  localparam logic [CntW-1:0] SlotsC = CntW'(SLOTS);

  logic [GEN_BITS-1:0]     gen_mem   [SLOTS];
  logic [CntW-1:0]         dpos_mem  [SLOTS];
  logic [CntW-1:0]         next_mem  [SLOTS];
  logic [PAYLOAD_BITS-1:0] pay_mem   [SLOTS];
  logic [IdxW-1:0]         dslot_mem [SLOTS];

  logic [GEN_BITS-1:0]     rd_gen;
  logic [CntW-1:0]         rd_dpos;
  logic [CntW-1:0]         rd_next;
  logic [PAYLOAD_BITS-1:0] rd_dpay;
  logic [IdxW-1:0]         rd_dslot;

  logic [GEN_BITS-1:0]     base_gen;
  logic [OwnerBits-1:0]    owner_id;
  logic [OwnerBits-1:0]    owner_id_next;
  logic [CntW-1:0]         free_head;
  logic [CntW-1:0]         slot_count;
  logic [CntW-1:0]         dense_count;

  action_t                 act_q;
  logic [OwnerBits-1:0]    owner_q;
  logic [IdxW-1:0]         idx_q;
  logic [GEN_BITS-1:0]     gen_q;
  logic [PAYLOAD_BITS-1:0] pay_q;

  logic [IdxW-1:0]         moved;
  logic [IdxW-1:0]         fix_pos;
  status_t                 res_status;
  logic [OwnerBits-1:0]    res_owner;
  logic [IdxW-1:0]         res_index;
  logic [GEN_BITS-1:0]     res_gen;
  logic [IdxW-1:0]         res_dpos;
  logic                    res_pay_en;

  logic                    do_alloc;
  logic [IdxW-1:0]         slot_ra;
  logic [IdxW-1:0]         alloc_s;
  logic [GEN_BITS-1:0]     alloc_gen;
  logic [IdxW-1:0]         pos;
  logic [CntW-1:0]         last;
  logic [IdxW-1:0]         dense_ra;
  logic                    dense_re;
  logic                    dpos_we;
  logic [IdxW-1:0]         dpos_wa;
  logic [CntW-1:0]         dpos_wd;
  logic [IdxW-1:0]         slot_wa;
  logic [CntW-1:0]         next_wd;
  logic [IdxW-1:0]         dense_wa;
  logic [PAYLOAD_BITS-1:0] pay_wd;
  logic [IdxW-1:0]         dslot_wd;

  always_comb begin
    do_alloc  = cmd.alloc_reuse || cmd.alloc_new;
    slot_ra   = (act_q == ACT_ALLOC) ? free_head[IdxW-1:0] : idx_q;
    alloc_s   = cmd.alloc_reuse ? free_head[IdxW-1:0] : slot_count[IdxW-1:0];
    alloc_gen = cmd.alloc_reuse ? rd_gen + GEN_BITS'(1) : base_gen;
    pos       = rd_dpos[IdxW-1:0];
    last      = dense_count - CntW'(1);
    dense_re  = cmd.fetch || cmd.read_entry;
    dense_ra  = cmd.fetch ? last[IdxW-1:0] : pos;
    dpos_we   = do_alloc || cmd.release_slot || cmd.fix;
    if (cmd.fix) begin
      dpos_wa = moved;
      dpos_wd = CntW'(fix_pos);
    end else if (cmd.release_slot) begin
      dpos_wa = idx_q;
      dpos_wd = SlotsC;
    end else begin
      dpos_wa = alloc_s;
      dpos_wd = dense_count;
    end
    slot_wa  = cmd.release_slot ? idx_q : alloc_s;
    next_wd  = cmd.release_slot ? free_head : SlotsC;
    dense_wa = cmd.release_slot ? pos : dense_count[IdxW-1:0];
    pay_wd   = cmd.release_slot ? rd_dpay : pay_q;
    dslot_wd = cmd.release_slot ? rd_dslot : alloc_s;
    owner_id_next = owner_id + OwnerBits'(1);
    if (owner_id_next == '0) begin
      owner_id_next = OwnerBits'(1);
    end
  end

  always_comb begin
    stat.act         = act_q;
    stat.can_reuse   = (free_head < SlotsC) && (dense_count < SlotsC);
    stat.can_new     = (free_head == SlotsC) && (slot_count < SlotsC)
                       && (dense_count < SlotsC);
    stat.handle_ok   = (owner_q != '0) && (owner_q == owner_id)
                       && (CntW'(idx_q) < slot_count) && (rd_gen == gen_q)
                       && (rd_dpos < dense_count);
    stat.pos_differs = (rd_dpos != last);
  end

  always_ff @(posedge clk) begin
    if (do_alloc) begin
      gen_mem[alloc_s] <= alloc_gen;
    end
    if (cmd.fetch) begin
      rd_gen <= gen_mem[slot_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (dpos_we) begin
      dpos_mem[dpos_wa] <= dpos_wd;
    end
    if (cmd.fetch) begin
      rd_dpos <= dpos_mem[slot_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (do_alloc || cmd.release_slot) begin
      next_mem[slot_wa] <= next_wd;
    end
    if (cmd.fetch) begin
      rd_next <= next_mem[slot_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (do_alloc || cmd.release_slot) begin
      pay_mem[dense_wa] <= pay_wd;
    end
    if (dense_re) begin
      rd_dpay <= pay_mem[dense_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (do_alloc || cmd.release_slot) begin
      dslot_mem[dense_wa] <= dslot_wd;
    end
    if (dense_re) begin
      rd_dslot <= dslot_mem[dense_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base_gen    <= '0;
      owner_id    <= OwnerBits'(1);
      free_head   <= SlotsC;
      slot_count  <= '0;
      dense_count <= '0;
    end else begin
      if (cfg_write) begin
        base_gen <= cfg_data;
      end
      if (cmd.clear) begin
        owner_id    <= owner_id_next;
        free_head   <= SlotsC;
        slot_count  <= '0;
        dense_count <= '0;
      end
      if (cmd.alloc_reuse) begin
        free_head <= rd_next;
      end
      if (cmd.alloc_new) begin
        slot_count <= slot_count + CntW'(1);
      end
      if (do_alloc) begin
        dense_count <= dense_count + CntW'(1);
      end
      if (cmd.release_slot) begin
        free_head   <= CntW'(idx_q);
        dense_count <= last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_q   <= action_t'(action);
      owner_q <= handle_owner;
      idx_q   <= handle_index;
      gen_q   <= handle_generation;
      pay_q   <= payload_in;
    end
    if (cmd.release_slot) begin
      moved   <= rd_dslot;
      fix_pos <= pos;
    end
    if (cmd.exec) begin
      res_status <= cmd.report;
      res_owner  <= do_alloc ? owner_id : '0;
      res_index  <= do_alloc ? alloc_s : '0;
      res_gen    <= do_alloc ? alloc_gen : '0;
      if (do_alloc) begin
        res_dpos <= dense_count[IdxW-1:0];
      end else if (cmd.read_entry) begin
        res_dpos <= pos;
      end else begin
        res_dpos <= '0;
      end
      res_pay_en <= cmd.read_entry;
    end
    if (cmd.load_out) begin
      status         <= res_status;
      out_owner      <= res_owner;
      out_index      <= res_index;
      out_generation <= res_gen;
      dense_position <= res_dpos;
      payload_out    <= res_pay_en ? rd_dpay : '0;
    end
  end

endmodule

@@ rtl/generational_slot_allocator_core.sv @@
// Top level of the generational slot allocator joining controller and datapath.
// An accepted request passes through the fetch, execute and finish states in that order;
// its result is registered at the output when finish ends. A request is taken only when
// idle, so each finishes before the next is taken; finish waits while a result stalls.
// Reset sets the owner id to 1, the base generation and all counts to zero and empties
// the free list; memory contents are not cleared, as entries are written before being read.
module generational_slot_allocator_core
  import gsa_pkg::*;
#(
  parameter int SLOTS        = SlotsDefault,
  parameter int GEN_BITS     = GenBitsDefault,
  parameter int PAYLOAD_BITS = PayloadBitsDefault,
  localparam int IdxW        = $clog2(SLOTS)
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_write,
  input  logic [GEN_BITS-1:0]     cfg_data,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [1:0]              action,
  input  logic [OwnerBits-1:0]    handle_owner,
  input  logic [IdxW-1:0]         handle_index,
  input  logic [GEN_BITS-1:0]     handle_generation,
  input  logic [PAYLOAD_BITS-1:0] payload_in,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [1:0]              status,
  output logic [OwnerBits-1:0]    out_owner,
  output logic [IdxW-1:0]         out_index,
  output logic [GEN_BITS-1:0]     out_generation,
  output logic [IdxW-1:0]         dense_position,
  output logic [PAYLOAD_BITS-1:0] payload_out
);

  gsa_cmd_t  cmd;
  gsa_stat_t stat;

  gsa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  gsa_datapath #(
    .SLOTS        (SLOTS),
    .GEN_BITS     (GEN_BITS),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_datapath (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .stat              (stat),
    .cfg_write         (cfg_write),
    .cfg_data          (cfg_data),
    .action            (action),
    .handle_owner      (handle_owner),
    .handle_index      (handle_index),
    .handle_generation (handle_generation),
    .payload_in        (payload_in),
    .status            (status),
    .out_owner         (out_owner),
    .out_index         (out_index),
    .out_generation    (out_generation),
    .dense_position    (dense_position),
    .payload_out       (payload_out)
  );

endmodule
